/* src/qloe_pkg.sv */
`default_nettype none

package qloe_pkg;

  // deepest level the hardware supports; leaf_index width fixes the upper bound
  localparam int unsigned MaxDepth = 3;
  localparam int unsigned LvlW     = $clog2(MaxDepth + 1);
  localparam int unsigned RowW     = (MaxDepth > 0) ? MaxDepth : 1;
  localparam int unsigned KW       = 2 * RowW;
  localparam int unsigned Cells    = 1 << RowW;
  localparam int unsigned CoordW   = 16 + 2 * MaxDepth + 2;
  localparam int unsigned IdxW     = 7;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [LvlW-1:0]          lvl_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WORLD_X    = 8'd0,
    REG_WORLD_Y    = 8'd1,
    REG_WORLD_SIDE = 8'd2,
    REG_TREE_DEPTH = 8'd3
  } cfg_reg_e;

  // first leaf index at a level: (4^l - 1) / 3
  function automatic logic [IdxW-1:0] leaf_base(lvl_t l);
    logic [IdxW-1:0] b;
    b = '0;
    for (int unsigned i = 0; i < MaxDepth; i++) begin
      if (i < l) begin
        b = IdxW'({b, 2'b00}) + IdxW'(1);
      end
    end
    return b;
  endfunction

endpackage

`default_nettype wire

/* src/qloe_if.sv */
`default_nettype none

interface qloe_rect_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic        [15:0] rect_w;
  logic        [15:0] rect_h;

  modport source (output valid, rect_x, rect_y, rect_w, rect_h, input ready);
  modport sink   (input valid, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface qloe_res_if;
  logic                       valid;
  logic                       ready;
  logic [qloe_pkg::IdxW-1:0]  leaf_index;
  logic                       hit;
  logic                       last;

  modport source (output valid, leaf_index, hit, last, input ready);
  modport sink   (input valid, leaf_index, hit, last, output ready);
endinterface

interface qloe_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [qloe_pkg::CfgIdxW-1:0]  index;
  logic [qloe_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/qloe_span_cmp.sv */
`default_nettype none

// strict overlap of [a0, a1) with the cell span [edge, edge + side)
module qloe_span_cmp (
  input  qloe_pkg::coord_t a0_i,
  input  qloe_pkg::coord_t a1_i,
  input  qloe_pkg::coord_t edge_i,
  input  qloe_pkg::coord_t side_i,
  output logic             hit_o
);

  qloe_pkg::coord_t edge_end;
  qloe_pkg::coord_t lo;
  qloe_pkg::coord_t hi;

  assign edge_end = edge_i + side_i;
  assign lo       = (a0_i > edge_i) ? a0_i : edge_i;
  assign hi       = (a1_i < edge_end) ? a1_i : edge_end;
  assign hit_o    = lo < hi;

endmodule

`default_nettype wire

/* src/quadtree_leaf_overlap_emitter_unit.sv */
`default_nettype none

// Reports every leaf of a complete square quadtree that a rectangle strictly overlaps, as
// tree-array indices in Z order, with last on the final one; a rectangle touching no leaf
// gives a single result with hit 0. Coordinates are scaled by 2^L, so the math is exact.
// After a rectangle is accepted, rect ready stays low until its final result is registered,
// so result-channel stalls keep it low longer. One span comparator builds a column mask and
// then a row mask, one cell per cycle, and then the leaf scan visits one leaf per cycle
// while the result register is free. Configuration writes are always taken and are meant
// for idle periods only.
module quadtree_leaf_overlap_emitter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  qloe_cfg_if.sink    cfg_i,
  qloe_rect_if.sink   rect_i,
  qloe_res_if.source  res_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_XM    = 3'd1;
  localparam logic [2:0] S_YM    = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  function automatic qloe_pkg::coord_t scale_s(logic signed [15:0] v, qloe_pkg::lvl_t l);
    return qloe_pkg::coord_t'(v) <<< l;
  endfunction

  function automatic qloe_pkg::coord_t scale_u(logic [15:0] v, qloe_pkg::lvl_t l);
    return qloe_pkg::coord_t'(v) <<< l;
  endfunction

  // configuration registers
  logic signed [15:0] world_x_q, world_y_q;
  logic [15:0]        world_side_q;
  logic [1:0]         tree_depth_q;

  logic [2:0]                      state_q, state_d;
  qloe_pkg::coord_t                rx0_q, rx0_d, rx1_q, rx1_d;
  qloe_pkg::coord_t                ry0_q, ry0_d, ry1_q, ry1_d;
  qloe_pkg::coord_t                edge_q, edge_d;
  logic [qloe_pkg::RowW-1:0]       cnt_q, cnt_d;
  logic [qloe_pkg::Cells-1:0]      xmask_q, xmask_d, ymask_q, ymask_d;
  logic [qloe_pkg::KW-1:0]         k_q, k_d;
  logic                            pend_valid_q, pend_valid_d;
  logic [qloe_pkg::IdxW-1:0]       pend_idx_q, pend_idx_d;
  logic                            res_valid_q, res_valid_d;
  logic [qloe_pkg::IdxW-1:0]       res_idx_q, res_idx_d;
  logic                            res_hit_q, res_hit_d;
  logic                            res_last_q, res_last_d;

  qloe_pkg::lvl_t              lvl;
  logic [qloe_pkg::RowW-1:0]   row_last;
  logic [qloe_pkg::KW-1:0]     k_last;
  logic [qloe_pkg::RowW-1:0]   col, row;
  logic [qloe_pkg::IdxW-1:0]   leaf_idx;
  logic                        leaf_hit;
  logic                        span_hit;
  logic                        out_free;
  logic                        rect_xfer;
  qloe_pkg::coord_t            side;
  qloe_pkg::coord_t            span_a0, span_a1;

  assign lvl = (32'(tree_depth_q) > qloe_pkg::MaxDepth) ? qloe_pkg::lvl_t'(qloe_pkg::MaxDepth)
                                                         : qloe_pkg::lvl_t'(tree_depth_q);
  assign row_last = ~({qloe_pkg::RowW{1'b1}} << lvl);
  assign k_last   = ~({qloe_pkg::KW{1'b1}} << {lvl, 1'b0});
  assign side     = qloe_pkg::coord_t'(world_side_q);

  // z order: even bits of k give the column, odd bits the row
  always_comb begin
    for (int unsigned b = 0; b < qloe_pkg::RowW; b++) begin
      col[b] = k_q[2*b];
      row[b] = k_q[2*b+1];
    end
  end

  assign leaf_hit = xmask_q[col] & ymask_q[row];
  assign leaf_idx = qloe_pkg::leaf_base(lvl)
                  + qloe_pkg::IdxW'(qloe_pkg::KW'(row) << lvl)
                  + qloe_pkg::IdxW'(col);

  assign span_a0 = (state_q == S_XM) ? rx0_q : ry0_q;
  assign span_a1 = (state_q == S_XM) ? rx1_q : ry1_q;

  qloe_span_cmp u_span (
    .a0_i   (span_a0),
    .a1_i   (span_a1),
    .edge_i (edge_q),
    .side_i (side),
    .hit_o  (span_hit)
  );

  assign rect_i.ready = (state_q == S_IDLE);
  assign rect_xfer    = rect_i.valid & rect_i.ready;
  assign out_free     = ~res_valid_q | res_o.ready;

  assign cfg_i.ready      = 1'b1;
  assign res_o.valid      = res_valid_q;
  assign res_o.leaf_index = res_idx_q;
  assign res_o.hit        = res_hit_q;
  assign res_o.last       = res_last_q;

  always_comb begin
    state_d      = state_q;
    rx0_d        = rx0_q;
    rx1_d        = rx1_q;
    ry0_d        = ry0_q;
    ry1_d        = ry1_q;
    edge_d       = edge_q;
    cnt_d        = cnt_q;
    xmask_d      = xmask_q;
    ymask_d      = ymask_q;
    k_d          = k_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    res_valid_d  = res_valid_q & ~res_o.ready;
    res_idx_d    = res_idx_q;
    res_hit_d    = res_hit_q;
    res_last_d   = res_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (rect_xfer) begin
          rx0_d        = scale_s(rect_i.rect_x, lvl);
          rx1_d        = scale_s(rect_i.rect_x, lvl) + scale_u(rect_i.rect_w, lvl);
          ry0_d        = scale_s(rect_i.rect_y, lvl);
          ry1_d        = scale_s(rect_i.rect_y, lvl) + scale_u(rect_i.rect_h, lvl);
          edge_d       = scale_s(world_x_q, lvl);
          cnt_d        = '0;
          pend_valid_d = 1'b0;
          state_d      = S_XM;
        end
      end
      S_XM: begin
        xmask_d[cnt_q] = span_hit;
        edge_d         = edge_q + side;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == row_last) begin
          cnt_d   = '0;
          edge_d  = scale_s(world_y_q, lvl);
          state_d = S_YM;
        end
      end
      S_YM: begin
        ymask_d[cnt_q] = span_hit;
        edge_d         = edge_q + side;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == row_last) begin
          cnt_d   = '0;
          k_d     = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (out_free) begin
          // a hit is held back one step so that last can be set on the final one
          if (leaf_hit) begin
            if (pend_valid_q) begin
              res_valid_d = 1'b1;
              res_idx_d   = pend_idx_q;
              res_hit_d   = 1'b1;
              res_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_idx_d   = leaf_idx;
          end
          if (k_q == k_last) begin
            state_d = S_FLUSH;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          res_valid_d  = 1'b1;
          res_idx_d    = pend_valid_q ? pend_idx_q : '0;
          res_hit_d    = pend_valid_q;
          res_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      world_x_q    <= '0;
      world_y_q    <= '0;
      world_side_q <= 16'd1024;
      tree_depth_q <= 2'd3;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        qloe_pkg::REG_WORLD_X:    world_x_q    <= cfg_i.data;
        qloe_pkg::REG_WORLD_Y:    world_y_q    <= cfg_i.data;
        qloe_pkg::REG_WORLD_SIDE: world_side_q <= cfg_i.data;
        qloe_pkg::REG_TREE_DEPTH: tree_depth_q <= cfg_i.data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      k_q          <= '0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      k_q          <= k_d;
      pend_valid_q <= pend_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rx0_q      <= rx0_d;
    rx1_q      <= rx1_d;
    ry0_q      <= ry0_d;
    ry1_q      <= ry1_d;
    edge_q     <= edge_d;
    xmask_q    <= xmask_d;
    ymask_q    <= ymask_d;
    pend_idx_q <= pend_idx_d;
    res_idx_q  <= res_idx_d;
    res_hit_q  <= res_hit_d;
    res_last_q <= res_last_d;
  end

  // a miss result is always the single, final one with index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_hit_q) |-> (res_last_q && res_idx_q == '0))
    else $error("miss result without last or with nonzero index");

  // hits always name a leaf of the current level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_hit_q) |->
      (res_idx_q >= qloe_pkg::leaf_base(lvl) &&
       32'(res_idx_q) < 32'(qloe_pkg::leaf_base(lvl)) + (1 << (2 * lvl))))
    else $error("hit index outside the leaf level");

  // mask counter stays within one row of cells
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_XM || state_q == S_YM) |-> (cnt_q <= row_last))
    else $error("cell counter past the last column");

  // no held-back hit survives the end of a rectangle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q)
    else $error("pending hit left over while idle");

  // an accepted rectangle always starts with the column mask pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_xfer |=> (state_q == S_XM && cnt_q == '0))
    else $error("rectangle transfer did not start the mask pass");

endmodule

`default_nettype wire

/* test/quadtree_leaf_overlap_emitter_unit_tb.sv */
`default_nettype none

module quadtree_leaf_overlap_emitter_unit_tb;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned SegItems      = 27;
  localparam int unsigned Segments      = 6;
  localparam int unsigned DrainCycles   = 200;
  localparam int unsigned PrintCap      = 50;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
  } rect_t;

  typedef struct packed {
    logic [qloe_pkg::IdxW-1:0] leaf_index;
    logic                      hit;
    logic                      last;
  } leaf_hit_t;

  typedef struct packed {
    logic                      is_cfg;
    qloe_pkg::cfg_reg_e        reg_idx;
    logic [15:0]               reg_data;
    rect_t                     rect;
    logic                      known;
    logic [qloe_pkg::IdxW-1:0] leaf_index;
    logic                      hit;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  qloe_cfg_if  cfg_if ();
  qloe_rect_if rect_if ();
  qloe_res_if  res_if ();

  quadtree_leaf_overlap_emitter_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .rect_i (rect_if),
    .res_o  (res_if)
  );

  // shadow copy of the configuration registers
  logic signed [15:0] world_x_q;
  logic signed [15:0] world_y_q;
  logic        [15:0] world_side_q;
  logic        [1:0]  tree_depth_q;

  leaf_hit_t   expected_hits [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        hold_req = 1'b0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report_mismatch(string msg);
    if (mismatches < PrintCap) begin
      $display("%0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic void add_expected(leaf_hit_t h);
    expected_hits.insert(expected_hits.size(), h);
  endfunction

  function automatic void add_row(stim_row_t s);
    directed_rows.insert(directed_rows.size(), s);
  endfunction

  function automatic bit spans_overlap(longint a0, longint a1, longint b0, longint b1);
    longint lo;
    longint hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return lo < hi;
  endfunction

  // work in units scaled by 2^L so a leaf is exactly world_side wide
  function automatic void predict_leaf_hits(rect_t r);
    int unsigned lvl;
    int unsigned per_row;
    int unsigned leaves;
    int unsigned base;
    int unsigned row;
    int unsigned col;
    longint      scale;
    longint      rx0;
    longint      rx1;
    longint      ry0;
    longint      ry1;
    longint      wx;
    longint      wy;
    longint      side;
    longint      cx0;
    longint      cy0;
    leaf_hit_t   hit_entry;
    leaf_hit_t   hits [$];
    lvl     = (tree_depth_q > qloe_pkg::MaxDepth) ? qloe_pkg::MaxDepth : tree_depth_q;
    scale   = longint'(1) << lvl;
    per_row = 1 << lvl;
    leaves  = per_row * per_row;
    base    = (leaves - 1) / 3;
    rx0     = longint'($signed(r.x)) * scale;
    ry0     = longint'($signed(r.y)) * scale;
    rx1     = rx0 + longint'(r.w) * scale;
    ry1     = ry0 + longint'(r.h) * scale;
    wx      = longint'(world_x_q) * scale;
    wy      = longint'(world_y_q) * scale;
    side    = longint'(world_side_q);
    for (int unsigned k = 0; k < leaves; k++) begin
      row = 0;
      col = 0;
      // z order: even bits of k give the column, odd bits the row
      for (int unsigned b = 0; b < lvl; b++) begin
        col |= ((k >> (2 * b)) & 1) << b;
        row |= ((k >> (2 * b + 1)) & 1) << b;
      end
      cx0 = wx + longint'(col) * side;
      cy0 = wy + longint'(row) * side;
      if (spans_overlap(rx0, rx1, cx0, cx0 + side) &&
          spans_overlap(ry0, ry1, cy0, cy0 + side)) begin
        hit_entry = '{leaf_index: qloe_pkg::IdxW'(base + row * per_row + col),
                      hit: 1'b1, last: 1'b0};
        hits = {hits, hit_entry};
      end
    end
    if (hits.size() == 0) begin
      add_expected('{leaf_index: '0, hit: 1'b0, last: 1'b1});
    end else begin
      hits[hits.size() - 1].last = 1'b1;
      foreach (hits[i]) begin
        add_expected(hits[i]);
      end
    end
  endfunction

  function automatic int clamp_to(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic rect_t make_rect();
    int    span;
    int    leaf_w;
    int    x;
    int    y;
    int    w;
    int    h;
    rect_t r;
    if ($urandom_range(99) < 80) begin
      span   = int'(world_side_q);
      leaf_w = span >> tree_depth_q;
      if (leaf_w == 0) begin
        leaf_w = 1;
      end
      x = int'(world_x_q) - span / 8 + int'($urandom_range(0, span + span / 4));
      y = int'(world_y_q) - span / 8 + int'($urandom_range(0, span + span / 4));
      // land edges on leaf boundaries now and then
      if ($urandom_range(2) == 0) begin
        x = int'(world_x_q) + leaf_w * int'($urandom_range(0, 8));
      end
      if ($urandom_range(2) == 0) begin
        y = int'(world_y_q) + leaf_w * int'($urandom_range(0, 8));
      end
      w = int'($urandom_range(0, span / 2 + 1));
      h = int'($urandom_range(0, span / 2 + 1));
      if ($urandom_range(2) == 0) begin
        w = leaf_w * int'($urandom_range(0, 3));
      end
      if ($urandom_range(2) == 0) begin
        h = leaf_w * int'($urandom_range(0, 3));
      end
      r.x = 16'(clamp_to(x, -32768, 32767));
      r.y = 16'(clamp_to(y, -32768, 32767));
      r.w = 16'(clamp_to(w, 0, 65535));
      r.h = 16'(clamp_to(h, 0, 65535));
    end else begin
      r = rect_t'({$urandom(), $urandom()});
    end
    return r;
  endfunction

  function automatic stim_row_t cfg_row(qloe_pkg::cfg_reg_e idx, logic [15:0] d);
    stim_row_t s;
    s          = '0;
    s.is_cfg   = 1'b1;
    s.reg_idx  = idx;
    s.reg_data = d;
    return s;
  endfunction

  function automatic stim_row_t rect_row(int x, int y, int w, int h);
    stim_row_t s;
    s        = '0;
    s.reg_idx = qloe_pkg::REG_WORLD_X;
    s.rect   = '{x: 16'(x), y: 16'(y), w: 16'(w), h: 16'(h)};
    return s;
  endfunction

  function automatic stim_row_t known_row(int x, int y, int w, int h, int leaf, bit hit);
    stim_row_t s;
    s            = rect_row(x, y, w, h);
    s.known      = 1'b1;
    s.leaf_index = qloe_pkg::IdxW'(leaf);
    s.hit        = hit;
    return s;
  endfunction

  task automatic send_rect(rect_t r, logic known, leaf_hit_t typed);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      rect_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    rect_if.valid  <= 1'b1;
    rect_if.rect_x <= r.x;
    rect_if.rect_y <= r.y;
    rect_if.rect_w <= r.w;
    rect_if.rect_h <= r.h;
    do @(posedge clk_i); while (!rect_if.ready);
    if (known) begin
      add_expected(typed);
    end else begin
      predict_leaf_hits(r);
    end
  endtask

  // sender pauses until every result is back and the scan has wound down
  task automatic wait_idle();
    @(negedge clk_i);
    rect_if.valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(qloe_pkg::cfg_reg_e idx, logic [15:0] d);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      qloe_pkg::REG_WORLD_X:    world_x_q    = d;
      qloe_pkg::REG_WORLD_Y:    world_y_q    = d;
      qloe_pkg::REG_WORLD_SIDE: world_side_q = d;
      qloe_pkg::REG_TREE_DEPTH: tree_depth_q = d[1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : res_sink
    int unsigned hold_left;
    hold_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    leaf_hit_t want;
    if ((rect_if.valid && rect_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (expected_hits.size() == 0) begin
        report_mismatch($sformatf("result %0d: leaf_index %0d hit %0d with nothing expected",
                                  results_seen, res_if.leaf_index, res_if.hit));
      end else begin
        want = expected_hits.pop_front();
        if (res_if.leaf_index !== want.leaf_index) begin
          report_mismatch($sformatf("result %0d: leaf_index got %0d, expected %0d",
                                    results_seen, res_if.leaf_index, want.leaf_index));
        end
        if (res_if.hit !== want.hit) begin
          report_mismatch($sformatf("result %0d: hit got %0d, expected %0d",
                                    results_seen, res_if.hit, want.hit));
        end
        if (res_if.last !== want.last) begin
          report_mismatch($sformatf("result %0d: last got %0d, expected %0d",
                                    results_seen, res_if.last, want.last));
        end
      end
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t   s;
    leaf_hit_t   typed;
    logic [1:0]  depth_d;
    logic [15:0] side_d;
    rst_ni         = 1'b0;
    rect_if.valid  = 1'b0;
    rect_if.rect_x = '0;
    rect_if.rect_y = '0;
    rect_if.rect_w = '0;
    rect_if.rect_h = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = qloe_pkg::REG_WORLD_X;
    cfg_if.data    = '0;
    world_x_q      = '0;
    world_y_q      = '0;
    world_side_q   = 16'd1024;
    tree_depth_q   = 2'd3;
    mismatches     = 0;
    results_seen   = 0;
    idle_cycles    = 0;
    send_idle_pct  = 15;
    recv_idle_pct  = 53;

    // reset layout: 8x8 leaves of 128 units, first leaf index 21
    add_row(known_row(0, 0, 1, 1, 21, 1'b1));
    add_row(known_row(0, 0, 0, 5, 0, 1'b0));
    add_row(known_row(0, 0, 5, 0, 0, 1'b0));
    add_row(known_row(1023, 1023, 1, 1, 84, 1'b1));
    add_row(known_row(1024, 0, 10, 10, 0, 1'b0));
    add_row(known_row(-10, -10, 10, 10, 0, 1'b0));
    add_row(rect_row(-32768, -32768, 65535, 65535));
    add_row(known_row(32767, 32767, 65535, 65535, 0, 1'b0));
    add_row(known_row(128, 0, 1, 1, 22, 1'b1));
    add_row(known_row(0, 128, 1, 1, 29, 1'b1));
    add_row(rect_row(127, 127, 2, 2));
    add_row(rect_row(-32768, 0, 65535, 1));
    // depth field only keeps its low two bits
    add_row(cfg_row(qloe_pkg::REG_TREE_DEPTH, 16'hFFFC));
    add_row(known_row(5, 5, 1, 1, 0, 1'b1));
    add_row(known_row(1024, 5, 1, 1, 0, 1'b0));
    add_row(cfg_row(qloe_pkg::REG_WORLD_SIDE, 16'h0000));
    add_row(known_row(0, 0, 100, 100, 0, 1'b0));
    add_row(cfg_row(qloe_pkg::REG_TREE_DEPTH, 16'h0002));
    add_row(cfg_row(qloe_pkg::REG_WORLD_SIDE, 16'd1000));
    add_row(rect_row(200, 200, 600, 100));
    // side not a multiple of eight, world pushed to the coordinate limits
    add_row(cfg_row(qloe_pkg::REG_WORLD_X, 16'h8000));
    add_row(cfg_row(qloe_pkg::REG_WORLD_Y, 16'h7FFF));
    add_row(cfg_row(qloe_pkg::REG_WORLD_SIDE, 16'hFFFF));
    add_row(cfg_row(qloe_pkg::REG_TREE_DEPTH, 16'h0003));
    add_row(rect_row(-32768, 32767, 65535, 1));
    add_row(rect_row(32767, -32768, 1, 65535));
    add_row(cfg_row(qloe_pkg::REG_WORLD_SIDE, 16'h0001));
    add_row(rect_row(-32768, 32767, 1, 1));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      s = directed_rows[i];
      if (s.is_cfg) begin
        wait_idle();
        write_reg(s.reg_idx, s.reg_data);
      end else begin
        typed = '{leaf_index: s.leaf_index, hit: s.hit, last: 1'b1};
        send_rect(s.rect, s.known, typed);
      end
    end

    for (int unsigned seg = 0; seg < Segments; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 53;
        recv_idle_pct = 15;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_idle();
      depth_d = ($urandom_range(1) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      side_d  = ($urandom_range(3) == 0) ? 16'($urandom()) :
                16'($urandom_range(1, 200) << depth_d);
      write_reg(qloe_pkg::REG_TREE_DEPTH, {14'($urandom()), depth_d});
      write_reg(qloe_pkg::REG_WORLD_SIDE, side_d);
      write_reg(qloe_pkg::REG_WORLD_X, ($urandom_range(3) == 0) ? 16'($urandom()) :
                                       16'(int'($urandom_range(0, 4000)) - 2000));
      write_reg(qloe_pkg::REG_WORLD_Y, ($urandom_range(3) == 0) ? 16'($urandom()) :
                                       16'(int'($urandom_range(0, 4000)) - 2000));
      // long result stall while rectangles keep coming, so the input backs up
      if (seg == 4) begin
        hold_req = 1'b1;
      end
      typed = '0;
      repeat (SegItems) send_rect(make_rect(), 1'b0, typed);
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    while (expected_hits.size() != 0) begin
      typed = expected_hits.pop_front();
      report_mismatch($sformatf("missing result: leaf_index %0d hit %0d",
                                typed.leaf_index, typed.hit));
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
src/qloe_pkg.sv
src/qloe_if.sv
src/qloe_span_cmp.sv
src/quadtree_leaf_overlap_emitter_unit.sv
test/quadtree_leaf_overlap_emitter_unit_tb.sv
